[src/assert_macros.svh]
// Assertion macros used by the ALU controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[src/xalu_pkg.sv]
package xalu_pkg;
  localparam logic [3:0] ACT_ADD = 4'd0, ACT_ADC = 4'd1, ACT_SUB = 4'd2, ACT_SBB = 4'd3,
    ACT_MUL = 4'd4, ACT_IMUL = 4'd5, ACT_DIV = 4'd6, ACT_IDIV = 4'd7, ACT_MOD = 4'd8,
    ACT_IMOD = 4'd9, ACT_AND = 4'd10, ACT_XOR = 4'd11, ACT_OR = 4'd12, ACT_SHL = 4'd13,
    ACT_SHR = 4'd14, ACT_SAR = 4'd15;
  localparam logic [1:0] SIZE_8 = 2'd0, SIZE_16 = 2'd1, SIZE_32 = 2'd2, SIZE_RESERVED = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture operands
    logic quick;     // compute quick-operation result
    logic mul;       // compute product from registered operands
    logic div_init;  // set up divide
    logic div_step;  // one quotient bit
    logic div_fin;   // produce divide result
  } xalu_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_zero;
  } xalu_stat_t;
endpackage

[src/xalu_ctrl.sv]
module xalu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output xalu_pkg::xalu_cmd_t cmd,
  input  xalu_pkg::xalu_stat_t stat
);
`include "assert_macros.svh"
  localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_MUL = 3'd2, S_DIV = 3'd3,
    S_FIN = 3'd4, S_OUT = 3'd5;
  logic [2:0] state, state_next;
  logic [5:0] count, count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_mul) begin
          state_next = S_MUL;
        end else if (stat.is_div && !stat.div_zero) begin
          cmd.div_init = 1'b1;
          count_next = 6'd0;
          state_next = S_DIV;
        end else begin
          cmd.quick = 1'b1;
          state_next = S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        count_next = count + 6'd1;
        if (count == 6'd63) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.div_fin = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)
  `ASSERT_IMPLIES(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))
endmodule

[src/xalu_dp.sv]
module xalu_dp (
  input  logic                 clk,
  input  xalu_pkg::xalu_cmd_t  cmd,
  output xalu_pkg::xalu_stat_t stat,
  input  logic [3:0]           action,
  input  logic [1:0]           size_sel,
  input  logic [31:0]          src_operand,
  input  logic [63:0]          dest_operand,
  input  logic                 carry_in,
  output logic [63:0]          result_value,
  output logic                 carry_flag,
  output logic                 parity_flag,
  output logic                 zero_flag,
  output logic                 sign_flag,
  output logic                 overflow_flag,
  output logic [4:0]           flag_write_mask,
  output logic                 divide_error
);
  logic [3:0]  act;
  logic [1:0]  sz;
  logic [31:0] s;
  logic [63:0] dfull;
  logic        cin;

  logic [63:0] r_q;
  logic [4:0]  fl_q, wm_q;
  logic        derr_q;

  logic [31:0] m, msb;
  logic [5:0]  n;
  logic [31:0] d, sn;
  always_comb begin
    if (sz == xalu_pkg::SIZE_8) begin
      m = 32'hFF; msb = 32'h80; n = 6'd8;
    end else if (sz == xalu_pkg::SIZE_16) begin
      m = 32'hFFFF; msb = 32'h8000; n = 6'd16;
    end else begin
      m = 32'hFFFF_FFFF; msb = 32'h8000_0000; n = 6'd32;
    end
    d = dfull[31:0] & m;
    sn = s & m;
  end

  logic is_sgn, is_quot;
  assign is_sgn = (act == xalu_pkg::ACT_IDIV) || (act == xalu_pkg::ACT_IMOD)
               || (act == xalu_pkg::ACT_IMUL);
  assign is_quot = (act == xalu_pkg::ACT_DIV) || (act == xalu_pkg::ACT_IDIV);

  assign stat.is_mul = (act == xalu_pkg::ACT_MUL) || (act == xalu_pkg::ACT_IMUL);
  assign stat.is_div = (act >= xalu_pkg::ACT_DIV) && (act <= xalu_pkg::ACT_IMOD);
  assign stat.div_zero = (sn == 32'd0);

  // Operands extended to 33 bits for the multiplier, sign-extended for signed actions.
  logic [32:0] ma, mb;
  logic [63:0] a2n, a2m;
  always_comb begin
    ma = {1'b0, d};
    mb = {1'b0, sn};
    if (is_sgn && ((d & msb) != 32'd0)) ma = {1'b1, d | ~m};
    if (is_sgn && ((sn & msb) != 32'd0)) mb = {1'b1, sn | ~m};
    if (sz == xalu_pkg::SIZE_8) a2m = 64'hFFFF;
    else if (sz == xalu_pkg::SIZE_16) a2m = 64'hFFFF_FFFF;
    else a2m = '1;
    a2n = dfull & a2m;
    // Sign-extend dividend from 2n bits.
    if (is_sgn && (((a2n >> (n + n - 6'd1)) & 64'd1) != 64'd0)) a2n = a2n | ~a2m;
  end

  logic [65:0] prod;
  assign prod = $signed(ma) * $signed(mb);

  // Quick operations.
  logic [63:0] q_r;
  logic [4:0]  q_fl, q_wm;
  always_comb begin
    logic [32:0] t;
    logic [31:0] r;
    logic [4:0]  c;
    logic        cf, of, szp, sgn;
    logic [32:0] sc;
    logic [63:0] v, sh;
    t = '0; r = '0; cf = 1'b0; of = 1'b0; szp = 1'b0; q_wm = '0;
    c = s[4:0]; sc = '0; v = '0; sh = '0; sgn = 1'b0;
    case (act)
      xalu_pkg::ACT_ADD, xalu_pkg::ACT_ADC: begin
        t = {1'b0, d} + {1'b0, sn} + {32'd0, (act == xalu_pkg::ACT_ADC) & cin};
        r = t[31:0] & m;
        cf = t[n];
        of = ((~(d ^ sn) & (d ^ r)) & msb) != 32'd0;
        q_wm = 5'h1F; szp = 1'b1;
      end
      xalu_pkg::ACT_SUB, xalu_pkg::ACT_SBB: begin
        sc = {1'b0, sn} + {32'd0, (act == xalu_pkg::ACT_SBB) & cin};
        t = {1'b0, d} - sc;
        r = t[31:0] & m;
        cf = {1'b0, d} < sc;
        of = (((d ^ sn) & (d ^ r)) & msb) != 32'd0;
        q_wm = 5'h1F; szp = 1'b1;
      end
      xalu_pkg::ACT_AND: begin r = d & sn; q_wm = 5'h1F; szp = 1'b1; end
      xalu_pkg::ACT_XOR: begin r = d ^ sn; q_wm = 5'h1F; szp = 1'b1; end
      xalu_pkg::ACT_OR:  begin r = d | sn; q_wm = 5'h1F; szp = 1'b1; end
      xalu_pkg::ACT_SHL, xalu_pkg::ACT_SHR, xalu_pkg::ACT_SAR: begin
        if (c == 5'd0) begin
          r = d;
        end else begin
          sgn = (d & msb) != 32'd0;
          if (act == xalu_pkg::ACT_SHL) begin
            sh = {32'd0, d} << c;
            r = sh[31:0] & m;
            cf = ({1'b0, c} <= n) ? sh[n] : 1'b0;
            of = ((r & msb) != 32'd0) ^ cf;
          end else begin
            v = (act == xalu_pkg::ACT_SAR && sgn) ? {32'hFFFF_FFFF, d | ~m}
                                                  : {32'd0, d};
            sh = 64'({v, 1'b0} >> c);
            r = sh[32:1] & m;
            cf = sh[0];
            of = (act == xalu_pkg::ACT_SHR) && sgn;
          end
          q_wm = (c == 5'd1) ? 5'h1F : 5'h0F;
          if (c != 5'd1) of = 1'b0;
          szp = 1'b1;
        end
      end
      default: ;
    endcase
    q_r = {32'd0, r};
    q_fl = {of, szp & ((r & msb) != 32'd0), szp & (r == 32'd0), szp & ~^r[7:0], cf};
  end

  // Shift-subtract divider over unsigned magnitudes; 64 steps.
  logic [63:0] dv_a;    // dividend shifting out
  logic [64:0] dv_rem;
  logic [31:0] dv_b;
  logic [63:0] dv_q;
  logic        dv_an, dv_bn;
  logic [64:0] trial;
  assign trial = {dv_rem[63:0], dv_a[63]} - {33'd0, dv_b};

  logic [63:0] qs, rs;
  always_comb begin
    qs = (dv_an != dv_bn) ? -dv_q : dv_q;
    rs = dv_an ? -dv_rem[63:0] : dv_rem[63:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action; sz <= size_sel; s <= src_operand;
      dfull <= dest_operand; cin <= carry_in;
    end
    if (cmd.div_init) begin
      dv_an <= is_sgn & a2n[63];
      dv_bn <= is_sgn & mb[32];
      dv_a <= (is_sgn & a2n[63]) ? -a2n : a2n;
      dv_b <= (is_sgn & mb[32]) ? -mb[31:0] : sn;
      dv_rem <= '0;
      dv_q <= '0;
    end
    if (cmd.div_step) begin
      dv_a <= {dv_a[62:0], 1'b0};
      if (!trial[64]) begin
        dv_rem <= trial;
        dv_q <= {dv_q[62:0], 1'b1};
      end else begin
        dv_rem <= {dv_rem[63:0], dv_a[63]};
        dv_q <= {dv_q[62:0], 1'b0};
      end
    end
    if (cmd.quick) begin
      derr_q <= stat.is_div;
      r_q <= stat.is_div ? 64'd0 : q_r;
      fl_q <= stat.is_div ? 5'd0 : q_fl;
      wm_q <= stat.is_div ? 5'd0 : q_wm;
    end
    if (cmd.mul) begin
      derr_q <= 1'b0;
      r_q <= prod[63:0] & a2m;
      wm_q <= 5'h11;
      if (is_sgn) begin
        fl_q <= {4'd0, 1'b0} | {5{(prod[63:0] & ~{32'd0, m}) !=
                ((prod[31:0] & msb) != 32'd0 ? ~{32'd0, m} : 64'd0)}} & 5'h11;
      end else begin
        fl_q <= {5{(prod[63:0] & ~{32'd0, m}) != 64'd0}} & 5'h11;
      end
    end
    if (cmd.div_fin) begin
      derr_q <= 1'b0;
      r_q <= (is_quot ? qs : rs) & {32'd0, m};
      fl_q <= '0;
      wm_q <= '0;
    end
  end

  assign result_value = r_q;
  assign carry_flag = fl_q[0];
  assign parity_flag = fl_q[1];
  assign zero_flag = fl_q[2];
  assign sign_flag = fl_q[3];
  assign overflow_flag = fl_q[4];
  assign flag_write_mask = wm_q;
  assign divide_error = derr_q;
endmodule

[src/x86_integer_alu_with_flags.sv]
// Channel  | Handshake          | Payload
// command  | start, busy        | action, size_sel, src_operand, dest_operand, carry_in
// result   | done (one cycle)   | result_value, flags, flag_write_mask, divide_error
// Quick operations and a zero divisor go from decode to the result state; multiplies add a
// multiply state; divide and remainder add a finish state after the 64-step divide loop.
// busy is high from the cycle after start until the result cycle ends.
// Synchronous reset returns the controller to idle; results cannot be stalled.
module x86_integer_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [3:0]  action,
  input  logic [1:0]  size_sel,
  input  logic [31:0] src_operand,
  input  logic [63:0] dest_operand,
  input  logic        carry_in,
  output logic [63:0] result_value,
  output logic        carry_flag,
  output logic        parity_flag,
  output logic        zero_flag,
  output logic        sign_flag,
  output logic        overflow_flag,
  output logic [4:0]  flag_write_mask,
  output logic        divide_error
);
  xalu_pkg::xalu_cmd_t  cmd;
  xalu_pkg::xalu_stat_t stat;

  xalu_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cmd(cmd), .stat(stat));

  xalu_dp u_dp (.clk(clk), .cmd(cmd), .stat(stat), .action(action),
    .size_sel(size_sel), .src_operand(src_operand), .dest_operand(dest_operand),
    .carry_in(carry_in), .result_value(result_value), .carry_flag(carry_flag),
    .parity_flag(parity_flag), .zero_flag(zero_flag), .sign_flag(sign_flag),
    .overflow_flag(overflow_flag), .flag_write_mask(flag_write_mask),
    .divide_error(divide_error));
endmodule
